>>> src/ncheck_pkg.sv
// Package for the NMEA sentence checker: result codes, character and tag
// constants, the parser-to-verdict summary struct and the hex digit decoder.
// No dependencies.
package ncheck_pkg;

   typedef logic [2:0] kind_type;
   typedef logic [2:0] status_type;

   localparam kind_type KIND_NONE = 3'd0;
   localparam kind_type KIND_HDG  = 3'd1;
   localparam kind_type KIND_DBT  = 3'd2;
   localparam kind_type KIND_VLW  = 3'd3;
   localparam kind_type KIND_VTG  = 3'd4;

   localparam status_type STATUS_ACCEPTED  = 3'd0;
   localparam status_type STATUS_NO_DOLLAR = 3'd1;
   localparam status_type STATUS_MISMATCH  = 3'd2;
   localparam status_type STATUS_FEW_FIELDS = 3'd3;
   localparam status_type STATUS_UNKNOWN   = 3'd4;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;

   localparam logic [23:0] TAG_HDG = 24'h484447;
   localparam logic [23:0] TAG_DBT = 24'h444254;
   localparam logic [23:0] TAG_VLW = 24'h564C57;
   localparam logic [23:0] TAG_VTG = 24'h565447;

   // bit 4 set marks a character that is not a hex digit
   localparam logic [4:0] HEX_INVALID = 5'h10;

   typedef struct packed {
      logic [7:0]  xor_sum;
      logic        dollar_ok;
      logic        hex_pair;
      logic [4:0]  hex_first;
      logic [4:0]  hex_second;
      logic        fields_ok;
      logic        addr_full;
      logic [23:0] addr_tail;
   } summary_type;

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = HEX_INVALID;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

>>> src/ncheck_parse.sv
// Input register and per-byte parser state of the NMEA sentence checker.
// Produces the sentence summary on the final byte. Depends on ncheck_pkg.
module ncheck_parse import ncheck_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_sentence
   input  logic        out_free,
   output logic        sum_valid,
   output summary_type summary
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        advance;

   logic        first_byte_next_ff, first_byte_next_in;
   logic        dollar_ok_ff, dollar_ok_in;
   logic        in_address_ff, in_address_in;
   logic [1:0]  address_len_ff, address_len_in;
   logic [23:0] address_tail_ff, address_tail_in;
   logic [1:0]  separator_count_ff, separator_count_in;
   logic        field_nonempty_ff, field_nonempty_in;
   logic [7:0]  xor_sum_ff, xor_sum_in;
   logic        star_seen_ff, star_seen_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [4:0]  hex_first_ff, hex_first_in;
   logic [4:0]  hex_second_ff, hex_second_in;

   logic        sep;
   logic [2:0]  field_total;

   // a non-final byte never waits on the result side
   assign advance     = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign sum_valid   = in_valid_ff && in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_comb begin
      first_byte_next_in = first_byte_next_ff;
      dollar_ok_in       = dollar_ok_ff;
      in_address_in      = in_address_ff;
      address_len_in     = address_len_ff;
      address_tail_in    = address_tail_ff;
      separator_count_in = separator_count_ff;
      field_nonempty_in  = field_nonempty_ff;
      xor_sum_in         = xor_sum_ff;
      star_seen_in       = star_seen_ff;
      hex_count_in       = hex_count_ff;
      hex_first_in       = hex_first_ff;
      hex_second_in      = hex_second_ff;

      sep = (in_byte_ff == CHAR_COMMA) || (in_byte_ff == CHAR_STAR);

      if (first_byte_next_ff) begin
         dollar_ok_in       = (in_byte_ff == CHAR_DOLLAR);
         first_byte_next_in = 1'b0;
      end else begin
         if (!star_seen_ff) begin
            if (in_byte_ff == CHAR_STAR) begin
               star_seen_in = 1'b1;
            end else begin
               xor_sum_in = xor_sum_ff ^ in_byte_ff;
            end
         end else if (hex_count_ff != 2'd2) begin
            if (hex_count_ff == 2'd0) begin
               hex_first_in = hex_value(in_byte_ff);
            end else begin
               hex_second_in = hex_value(in_byte_ff);
            end
            hex_count_in = hex_count_ff + 2'd1;
         end
         if (!sep && in_address_ff) begin
            address_tail_in = {address_tail_ff[15:0], in_byte_ff};
            if (address_len_ff != 2'd3) begin
               address_len_in = address_len_ff + 2'd1;
            end
         end
      end

      if (sep) begin
         in_address_in     = 1'b0;
         field_nonempty_in = 1'b0;
         if (separator_count_ff != 2'd3) begin
            separator_count_in = separator_count_ff + 2'd1;
         end
      end else begin
         field_nonempty_in = 1'b1;
      end

      field_total = {1'b0, separator_count_in} + {2'b00, field_nonempty_in};

      summary.xor_sum    = xor_sum_in;
      summary.dollar_ok  = dollar_ok_in;
      summary.hex_pair   = (hex_count_in == 2'd2);
      summary.hex_first  = hex_first_in;
      summary.hex_second = hex_second_in;
      summary.fields_ok  = (field_total >= 3'd2);
      summary.addr_full  = (address_len_in == 2'd3);
      summary.addr_tail  = address_tail_in;
   end

   // the final byte returns every parser register to its idle value
   always_ff @(posedge clock) begin
      if (reset || (advance && in_last_ff)) begin
         first_byte_next_ff <= 1'b1;
         dollar_ok_ff       <= 1'b0;
         in_address_ff      <= 1'b1;
         address_len_ff     <= 2'd0;
         address_tail_ff    <= 24'd0;
         separator_count_ff <= 2'd0;
         field_nonempty_ff  <= 1'b0;
         xor_sum_ff         <= 8'd0;
         star_seen_ff       <= 1'b0;
         hex_count_ff       <= 2'd0;
         hex_first_ff       <= 5'd0;
         hex_second_ff      <= 5'd0;
      end else if (advance) begin
         first_byte_next_ff <= first_byte_next_in;
         dollar_ok_ff       <= dollar_ok_in;
         in_address_ff      <= in_address_in;
         address_len_ff     <= address_len_in;
         address_tail_ff    <= address_tail_in;
         separator_count_ff <= separator_count_in;
         field_nonempty_ff  <= field_nonempty_in;
         xor_sum_ff         <= xor_sum_in;
         star_seen_ff       <= star_seen_in;
         hex_count_ff       <= hex_count_in;
         hex_first_ff       <= hex_first_in;
         hex_second_ff      <= hex_second_in;
      end
   end

   a_clear_after_final: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> first_byte_next_ff && hex_count_ff == 2'd0
                                && !star_seen_ff && xor_sum_ff == 8'd0)
      else $error("parser state not cleared after final byte");

   a_hex_count_bound: assert property (@(posedge clock) disable iff (reset)
      hex_count_ff != 2'd3)
      else $error("hex digit count overran");

endmodule

>>> src/ncheck_verdict.sv
// Verdict logic and result register of the NMEA sentence checker: checksum
// compare, field count and type match. Depends on ncheck_pkg.
module ncheck_verdict import ncheck_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        sum_valid,
   input  summary_type summary,
   output logic        out_free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] sentence_kind, [5:3] status,
                                    // [13:6] computed_sum, [14] sum_checked
);

   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   kind_ff, kind_in;
   status_type status_ff, status_in;
   logic [7:0] sum_ff, sum_in;
   logic       checked_ff, checked_in;

   logic [7:0] expect_sum;
   kind_type   tag_kind;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = out_free ? sum_valid : rsp_valid_ff;

   always_comb begin
      if (summary.hex_second[4]) begin
         expect_sum = {4'b0000, summary.hex_first[3:0]};
      end else begin
         expect_sum = {summary.hex_first[3:0], summary.hex_second[3:0]};
      end

      tag_kind = KIND_NONE;
      if (summary.addr_full) begin
         priority if (summary.addr_tail == TAG_HDG) begin
            tag_kind = KIND_HDG;
         end else if (summary.addr_tail == TAG_DBT) begin
            tag_kind = KIND_DBT;
         end else if (summary.addr_tail == TAG_VLW) begin
            tag_kind = KIND_VLW;
         end else if (summary.addr_tail == TAG_VTG) begin
            tag_kind = KIND_VTG;
         end else begin
            tag_kind = KIND_NONE;
         end
      end

      kind_in    = KIND_NONE;
      sum_in     = 8'd0;
      checked_in = 1'b0;
      if (!summary.dollar_ok) begin
         status_in = STATUS_NO_DOLLAR;
      end else begin
         sum_in     = summary.xor_sum;
         checked_in = summary.hex_pair && !summary.hex_first[4];
         priority if (checked_in && (expect_sum != summary.xor_sum)) begin
            status_in = STATUS_MISMATCH;
         end else if (!summary.fields_ok) begin
            status_in = STATUS_FEW_FIELDS;
         end else if (tag_kind == KIND_NONE) begin
            status_in = STATUS_UNKNOWN;
         end else begin
            status_in = STATUS_ACCEPTED;
            kind_in   = tag_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_valid && out_free) begin
         kind_ff    <= kind_in;
         status_ff  <= status_in;
         sum_ff     <= sum_in;
         checked_ff <= checked_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, checked_ff, sum_ff, status_ff, kind_ff};

   a_kind_only_when_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != KIND_NONE |-> status_ff == STATUS_ACCEPTED)
      else $error("sentence kind set on a rejected sentence");

   a_no_dollar_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STATUS_NO_DOLLAR |-> sum_ff == 8'd0 && !checked_ff)
      else $error("sum reported for sentence without leading dollar");

   a_mismatch_checked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STATUS_MISMATCH |-> checked_ff)
      else $error("checksum mismatch without a parsed checksum");

endmodule

>>> src/nmea_sentence_checker_unit.sv
// Top level of the NMEA 0183 sentence checker.
// Instantiates ncheck_parse and ncheck_verdict; depends on ncheck_pkg.
//
//   channel | direction | tdata                                  | tlast
//   req     | in        | [7:0] data_byte                        | end_of_sentence
//   rsp     | out       | [2:0] kind [5:3] status [13:6] sum     | none
//           |           | [14] sum_checked                       |
//
// One byte per cycle while no final byte waits; a byte passes the input register,
// and the result register takes a sentence's result as its final byte leaves.
// Only the final byte of a sentence waits on rsp_tready; other bytes never stall.
// Reset (synchronous, active high) empties both registers and clears the parser.
// A stalled result holds while the next sentence's bytes keep flowing in.
module nmea_sentence_checker_unit import ncheck_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_sentence
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] sentence_kind, [5:3] status,
                                    // [13:6] computed_sum, [14] sum_checked
);

   logic        out_free;
   logic        sum_valid;
   summary_type summary;

   ncheck_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .out_free   (out_free),
      .sum_valid  (sum_valid),
      .summary    (summary)
   );

   ncheck_verdict u_verdict (
      .clock      (clock),
      .reset      (reset),
      .sum_valid  (sum_valid),
      .summary    (summary),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/nmea_verdict_checker.sv
// Scoreboard for nmea_sentence_checker_unit: follows each sentence byte by byte,
// predicts the verdict on its final byte and compares it with the rsp transfer.
// Depends on ncheck_pkg.
module nmea_verdict_checker
   import ncheck_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_sentence
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [2:0] sentence_kind, [5:3] status,
                                    // [13:6] computed_sum, [14] sum_checked
   output int          verdicts_pending,
   output int          mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        at_start;
      logic        saw_dollar;
      logic        in_addr;
      logic [1:0]  addr_len;
      logic [23:0] addr_tail;
      logic [1:0]  sep_cnt;
      logic        field_open;
      logic [7:0]  running_xor;
      logic        star;
      logic [1:0]  digit_cnt;
      logic [4:0]  digit_hi;
      logic [4:0]  digit_lo;
   } parser_type;

   typedef struct packed {
      kind_type   kind;
      status_type status;
      logic [7:0] sum;
      logic       checked;
   } verdict_type;

   parser_type  sentence;
   verdict_type pending_verdicts[$];

   function automatic parser_type fresh_parser();
      parser_type s;
      s = '0;
      s.at_start = 1'b1;
      s.in_addr  = 1'b1;
      return s;
   endfunction

   function automatic logic [4:0] nibble_of_char(logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - 8'h30);
      if (c >= "A" && c <= "F") return 5'(c - 8'h41 + 8'd10);
      if (c >= "a" && c <= "f") return 5'(c - 8'h61 + 8'd10);
      return HEX_INVALID;
   endfunction

   function automatic parser_type absorb_char(parser_type s, logic [7:0] b);
      logic is_sep;
      is_sep = (b == CHAR_COMMA) || (b == CHAR_STAR);
      if (s.at_start) begin
         s.saw_dollar = (b == CHAR_DOLLAR);
         s.at_start   = 1'b0;
      end else begin
         // the sum stops at the first star; the next two bytes are the checksum
         if (!s.star) begin
            if (b == CHAR_STAR) s.star = 1'b1;
            else s.running_xor ^= b;
         end else if (s.digit_cnt < 2'd2) begin
            if (s.digit_cnt == 2'd0) s.digit_hi = nibble_of_char(b);
            else s.digit_lo = nibble_of_char(b);
            s.digit_cnt = s.digit_cnt + 2'd1;
         end
         if (!is_sep && s.in_addr) begin
            s.addr_tail = {s.addr_tail[15:0], b};
            if (s.addr_len < 2'd3) s.addr_len = s.addr_len + 2'd1;
         end
      end
      if (is_sep) begin
         s.in_addr    = 1'b0;
         if (s.sep_cnt < 2'd3) s.sep_cnt = s.sep_cnt + 2'd1;
         s.field_open = 1'b0;
      end else begin
         s.field_open = 1'b1;
      end
      return s;
   endfunction

   function automatic verdict_type settle_verdict(parser_type s);
      verdict_type v;
      logic [7:0]  sent_sum;
      v = '{kind: KIND_NONE, status: STATUS_ACCEPTED, sum: 8'h00, checked: 1'b0};
      if (!s.saw_dollar) begin
         v.status = STATUS_NO_DOLLAR;
         return v;
      end
      v.sum = s.running_xor;
      if (s.digit_cnt == 2'd2 && !s.digit_hi[4]) begin
         // a bad second digit leaves the first one as the whole value
         sent_sum = s.digit_lo[4] ? {4'h0, s.digit_hi[3:0]} : {s.digit_hi[3:0], s.digit_lo[3:0]};
         v.checked = 1'b1;
         if (sent_sum != s.running_xor) v.status = STATUS_MISMATCH;
      end
      if (v.status == STATUS_ACCEPTED && ({1'b0, s.sep_cnt} + 3'(s.field_open)) < 3'd2)
         v.status = STATUS_FEW_FIELDS;
      if (v.status == STATUS_ACCEPTED) begin
         if (s.addr_len == 2'd3) begin
            unique case (s.addr_tail)
               TAG_HDG: v.kind = KIND_HDG;
               TAG_DBT: v.kind = KIND_DBT;
               TAG_VLW: v.kind = KIND_VLW;
               TAG_VTG: v.kind = KIND_VTG;
               default: v.kind = KIND_NONE;
            endcase
         end
         if (v.kind == KIND_NONE) v.status = STATUS_UNKNOWN;
      end
      return v;
   endfunction

   task automatic report_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         sentence = fresh_parser();
         pending_verdicts.delete();
         mismatch_count = 0;
      end else begin
         // compare before predicting: a verdict never leaves on the edge its byte enters
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual tdata 0x%04h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = pending_verdicts.pop_front();
               report_field("sentence_kind", want.kind, rsp_tdata[2:0]);
               report_field("status", want.status, rsp_tdata[5:3]);
               report_field("computed_sum", want.sum, rsp_tdata[13:6]);
               report_field("sum_checked", want.checked, rsp_tdata[14]);
            end
         end
         if (req_tvalid && req_tready) begin
            sentence = absorb_char(sentence, req_tdata);
            if (req_tlast) begin
               pending_verdicts.insert(pending_verdicts.size(), settle_verdict(sentence));
               sentence = fresh_parser();
            end
         end
      end
      verdicts_pending <= pending_verdicts.size();
   end

endmodule

>>> tb/tb_nmea_sentence_checker_unit.sv
// Testbench top for nmea_sentence_checker_unit: drives directed and random NMEA
// sentences with random backpressure and gives the verdict.
// Depends on ncheck_pkg, nmea_sentence_checker_unit and nmea_verdict_checker.
module tb_nmea_sentence_checker_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import ncheck_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_BYTES  = 480;
   localparam int MIN_SENTENCES = 24;
   localparam int QUIET_AFTER   = 380;
   localparam int DRAIN_CYCLES  = 8;

   typedef enum {SUM_NONE, SUM_GOOD, SUM_BAD, SUM_ONE_DIGIT, SUM_BAD_FIRST,
                 SUM_BAD_SECOND} sum_form_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   int verdicts_pending;
   int mismatch_count;
   int stall_left = 0;
   int idle_cycles = 0;
   int bytes_sent = 0;
   int sentences_sent = 0;
   bit quiet = 1'b0;

   logic [7:0] line_bytes[$];

   always #6 clock = ~clock;

   nmea_sentence_checker_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   nmea_verdict_checker u_verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .verdicts_pending (verdicts_pending),
      .mismatch_count   (mismatch_count)
   );

   // result side: random stall bursts on rsp_tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_nmea_sentence_checker_unit: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] hex_char(logic [3:0] n, logic lower);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] body_xor();
      logic [7:0] x;
      x = 8'h00;
      for (int i = 1; i < line_bytes.size(); i++) x ^= line_bytes[i];
      return x;
   endfunction

   function automatic logic [7:0] upper_letter();
      return 8'h41 + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] field_char();
      unique case ($urandom_range(0, 15))
         0:          return 8'($urandom_range(0, 255));
         7:          return ".";
         14:         return 8'h61 + 8'($urandom_range(0, 25));
         15:         return "-";
         8, 9, 10, 11, 12, 13: return upper_letter();
         default:    return 8'h30 + 8'($urandom_range(0, 9));
      endcase
   endfunction

   task automatic append_byte(logic [7:0] b);
      line_bytes.insert(line_bytes.size(), b);
   endtask

   task automatic add_text(string t);
      for (int i = 0; i < t.len(); i++) append_byte(t[i]);
   endtask

   task automatic add_tag(logic [23:0] tag);
      append_byte(tag[23:16]);
      append_byte(tag[15:8]);
      append_byte(tag[7:0]);
   endtask

   task automatic add_sum(logic [7:0] v, logic lower);
      append_byte(hex_char(v[7:4], lower));
      append_byte(hex_char(v[3:0], lower));
   endtask

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      if (!quiet && $urandom_range(0, 6) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_bytes.size(); i++)
         send_byte(line_bytes[i], i == line_bytes.size() - 1);
      line_bytes.delete();
      sentences_sent++;
   endtask

   // drop the request and hold until every verdict in flight has come out
   task automatic wait_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
   endtask

   task automatic directed_lines();
      add_text("$HDG,12.5,T");
      send_line();
      add_text("$SDDBT,1.2,f");
      add_sum(body_xor(), 1'b0);
      line_bytes.insert(line_bytes.size() - 2, CHAR_STAR);
      send_line();
      add_text("$IIVLW,3,N");
      append_byte(CHAR_STAR);
      add_sum(body_xor() ^ CHAR_STAR, 1'b1);
      send_line();
      add_text("$GPVTG,0");
      append_byte(CHAR_STAR);
      add_sum(body_xor() ^ CHAR_STAR ^ 8'h5A, 1'b0);
      send_line();
      add_text("HDG,1*00");
      send_line();
      add_text("$VTG");
      send_line();
      add_text("$DG,1");
      send_line();
      add_text("$ABCDE,1");
      send_line();
      // first checksum digit not hex: passes unchecked
      add_text("$HDG,1*Z7");
      send_line();
      // second digit not hex: the single digit is the whole value
      add_text("$HDG,1Q*7G");
      send_line();
      add_text("$HDG,1*4");
      send_line();
      add_text("$");
      send_line();
      append_byte(8'hFF);
      send_line();
      add_text("$HDG,");
      append_byte(8'h00);
      append_byte(8'hFF);
      send_line();
      add_text("*,$");
      send_line();
      add_text("$DBT,,*");
      send_line();
   endtask

   task automatic random_line();
      sum_form_type form;
      logic [7:0]   good;
      int           pick;
      if ($urandom_range(0, 99) < 12) begin
         // noise: any bytes at all
         repeat ($urandom_range(1, 10)) append_byte(8'($urandom_range(0, 255)));
         send_line();
         return;
      end
      if ($urandom_range(0, 19) == 0) append_byte(8'($urandom_range(0, 255)));
      else append_byte(CHAR_DOLLAR);
      repeat ($urandom_range(0, 2)) append_byte(upper_letter());
      pick = $urandom_range(0, 9);
      unique case (pick)
         0, 1:    add_tag(TAG_HDG);
         2, 3:    add_tag(TAG_DBT);
         4, 5:    add_tag(TAG_VLW);
         6, 7:    add_tag(TAG_VTG);
         8:       repeat (3) append_byte(upper_letter());
         default: repeat ($urandom_range(0, 2)) append_byte(upper_letter());
      endcase
      repeat ($urandom_range(0, 4)) begin
         append_byte(CHAR_COMMA);
         repeat ($urandom_range(0, 5)) append_byte(field_char());
      end
      pick = $urandom_range(0, 9);
      unique case (pick)
         0:       form = SUM_NONE;
         6:       form = SUM_BAD;
         7:       form = SUM_ONE_DIGIT;
         8:       form = SUM_BAD_FIRST;
         9:       form = SUM_BAD_SECOND;
         default: form = SUM_GOOD;
      endcase
      good = body_xor();
      if (form != SUM_NONE) append_byte(CHAR_STAR);
      unique case (form)
         SUM_GOOD: begin
            append_byte(hex_char(good[7:4], 1'($urandom_range(0, 1))));
            append_byte(hex_char(good[3:0], 1'($urandom_range(0, 1))));
         end
         SUM_BAD:        add_sum(good ^ 8'($urandom_range(1, 255)),
                                 1'($urandom_range(0, 1)));
         SUM_ONE_DIGIT:  append_byte(hex_char(good[3:0], 1'b0));
         SUM_BAD_FIRST: begin
            append_byte(8'h47 + 8'($urandom_range(0, 19)));
            append_byte(hex_char(good[3:0], 1'b0));
         end
         SUM_BAD_SECOND: begin
            append_byte(hex_char(good[3:0], 1'($urandom_range(0, 1))));
            append_byte(8'h47 + 8'($urandom_range(0, 19)));
         end
         default: ;
      endcase
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(0, 255)));
      send_line();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      directed_lines();
      wait_results();
      bytes_sent     = 0;
      sentences_sent = 0;
      while (bytes_sent < RANDOM_BYTES || sentences_sent < MIN_SENTENCES) begin
         if (sentences_sent == 20) wait_results();
         if (bytes_sent >= QUIET_AFTER) quiet = 1'b1;
         random_line();
      end
      req_tvalid <= 1'b0;
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("tb_nmea_sentence_checker_unit: PASS");
      end else begin
         $display("tb_nmea_sentence_checker_unit: FAIL");
      end
      $finish;
   end

endmodule
